// File: rtl/tpgt_pkg.sv
// shared widths, constants and beat types for the triangle point geometry tests
package tpgt_pkg;

  localparam int COORD_BITS       = 16;
  localparam int CENTER_FRAC_BITS = 8;
  localparam int OUT_BITS         = 32;

  // coordinate differences and products
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SQ_W    = PROD_W + 1;

  // incircle terms, squared length split in two halves for the multipliers
  localparam int SPLIT_LO = (SQ_W + 1) / 2;
  localparam int SPLIT_HI = SQ_W - SPLIT_LO;
  localparam int PLO_W    = SPLIT_LO + 1 + CROSS_W;
  localparam int PHI_W    = SPLIT_HI + 1 + CROSS_W;
  localparam int TERM_W   = SQ_W + 1 + CROSS_W;
  localparam int DET_W    = TERM_W + 2;

  // circumcenter numerator, denominator and divider
  localparam int LP_W   = SQ_W + 1 + DIFF_W;
  localparam int NUM_W  = LP_W + 1;
  localparam int DEN_W  = CROSS_W + 2;
  localparam int MAG_W  = NUM_W + CENTER_FRAC_BITS + 2;
  localparam int WIDE_W = (OUT_BITS > COORD_BITS + CENTER_FRAC_BITS) ?
                          OUT_BITS : COORD_BITS + CENTER_FRAC_BITS;
  localparam int Q_W    = WIDE_W + 2;
  localparam int HI_W   = MAG_W - Q_W;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int REM_W  = DEN_W;
  localparam int SUM_W  = Q_W + 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex1_x;
    logic signed [COORD_BITS-1:0] vertex1_y;
    logic signed [COORD_BITS-1:0] vertex2_x;
    logic signed [COORD_BITS-1:0] vertex2_y;
    logic signed [COORD_BITS-1:0] vertex3_x;
    logic signed [COORD_BITS-1:0] vertex3_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic                       is_clockwise;
    logic                       in_circumcircle;
    logic                       in_triangle;
    logic                       is_degenerate;
    logic signed [OUT_BITS-1:0] center_x;
    logic signed [OUT_BITS-1:0] center_y;
  } out_item_t;

  typedef struct packed {
    logic is_clockwise;
    logic in_circumcircle;
    logic in_triangle;
    logic is_degenerate;
  } flags_t;

  typedef struct packed {
    logic                         neg;
    logic                         ovf;
    logic signed [COORD_BITS-1:0] base;
    logic [REM_W-1:0]             rem;
    logic [Q_W-1:0]               acc;
  } lane_t;

  typedef struct packed {
    flags_t                       flags;
    logic                         neg_x;
    logic                         neg_y;
    logic [MAG_W-1:0]             mag_x;
    logic [MAG_W-1:0]             mag_y;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic [DEN_W-1:0]             den;
  } div_in_t;

  typedef struct packed {
    flags_t           flags;
    lane_t            lane_x;
    lane_t            lane_y;
    logic [DEN_W-1:0] den;
  } div_stage_t;

endpackage

// File: rtl/triangle_point_geometry_tests.sv
// top level of the triangle point geometry tests pipeline
//
// one input beat per clock: pulse start with a triangle (three vertices) and a
// query point on item_i; busy is always low, so every cycle can take a beat
// each beat gives exactly one result beat on result_o, marked by done_o for
// exactly one cycle, in the order the beats went in
// result: orientation, on-or-inside circumcircle, inside triangle, collinear
// flag and the circumcenter in saturated signed fixed point, rounded to nearest
// pipeline: 5 front stages (differences, products, wide partial products,
//   sums, incircle decision and dividend), 1 divider setup stage, one stage
//   per quotient bit (34), and the result register
// throughput: one beat per cycle, set by the fully pipelined divider
// reset clears only the valid bits, so no result strobe follows reset until
// new beats arrive; data registers are not reset
// the receiver has no stall: results must be taken in the done_o cycle
module triangle_point_geometry_tests (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  tpgt_pkg::in_item_t  item_i,
  output logic                busy,
  output logic                done_o,
  output tpgt_pkg::out_item_t result_o
);

  logic                 front_valid;
  tpgt_pkg::div_in_t    front_data;
  logic                 div_valid;
  tpgt_pkg::div_stage_t div_data;
  logic                 accept;

  // no back pressure anywhere in the pipe
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  tpgt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  // both circumcenter coordinates share one denominator
  tpgt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  tpgt_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .data_i   (div_data),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// File: rtl/tpgt_front.sv
// front pipeline: differences, products, determinant sums and divider operands
module tpgt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tpgt_pkg::in_item_t item_i,
  output logic               valid_o,
  output tpgt_pkg::div_in_t  data_o
);

  localparam int CB  = tpgt_pkg::COORD_BITS;
  localparam int DW  = tpgt_pkg::DIFF_W;
  localparam int PW  = tpgt_pkg::PROD_W;
  localparam int CRW = tpgt_pkg::CROSS_W;
  localparam int SQW = tpgt_pkg::SQ_W;
  localparam int LO  = tpgt_pkg::SPLIT_LO;
  localparam int PLW = tpgt_pkg::PLO_W;
  localparam int PHW = tpgt_pkg::PHI_W;
  localparam int TW  = tpgt_pkg::TERM_W;
  localparam int DTW = tpgt_pkg::DET_W;
  localparam int LPW = tpgt_pkg::LP_W;
  localparam int NW  = tpgt_pkg::NUM_W;
  localparam int DNW = tpgt_pkg::DEN_W;
  localparam int MW  = tpgt_pkg::MAG_W;
  localparam int FB  = tpgt_pkg::CENTER_FRAC_BITS;

  typedef struct packed {
    logic signed [DW-1:0] bx, by, cx, cy;
    logic signed [DW-1:0] adx, ady, bdx, bdy, cdx, cdy;
    logic signed [DW-1:0] e2x, e2y, e3x, e3y;
    logic signed [CB-1:0] base_x, base_y;
  } s1_t;

  typedef struct packed {
    logic signed [CRW-1:0] area2, c1, c2, c3;
    logic [SQW-1:0]        a2, b2, cc2, lb, lc;
    logic signed [CRW-1:0] ma, mb, mc;
    logic signed [DW-1:0]  bx, by, cx, cy;
    logic signed [CB-1:0]  base_x, base_y;
  } s2_t;

  typedef struct packed {
    logic signed [PLW-1:0] pal, pbl, pcl;
    logic signed [PHW-1:0] pah, pbh, pch;
    logic signed [LPW-1:0] lb_cy, lc_by, lc_bx, lb_cx;
    logic                  cw, deg, intri;
    logic [DNW-1:0]        den;
    logic signed [CB-1:0]  base_x, base_y;
  } s3_t;

  typedef struct packed {
    logic signed [DTW-1:0] det;
    logic signed [NW-1:0]  nx, ny;
    logic                  cw, deg, intri;
    logic [DNW-1:0]        den;
    logic signed [CB-1:0]  base_x, base_y;
  } s4_t;

  function automatic logic signed [DW-1:0] sub(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  // a*b - c*d
  function automatic logic signed [CRW-1:0] xprod(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b,
                                                  input logic signed [DW-1:0] c,
                                                  input logic signed [DW-1:0] d);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    p = a * b;
    q = c * d;
    return CRW'(p) - CRW'(q);
  endfunction

  function automatic logic [SQW-1:0] sqsum(input logic signed [DW-1:0] a,
                                           input logic signed [DW-1:0] b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    p = a * a;
    q = b * b;
    return SQW'($unsigned(p)) + SQW'($unsigned(q));
  endfunction

  function automatic logic le_zero(input logic signed [CRW-1:0] v);
    return v[CRW-1] | (v == '0);
  endfunction

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  tpgt_pkg::div_in_t s5_d, s5_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic [CRW-1:0]        abs_area;
  logic signed [TW-1:0]  ta, tb, tc;
  logic                  det_neg, det_zero;
  logic [NW-1:0]         abs_nx, abs_ny;
  logic [MW-1:0]         half_den;

  // stage 1: coordinate differences
  always_comb begin
    s1_d.bx     = sub(item_i.vertex2_x, item_i.vertex1_x);
    s1_d.by     = sub(item_i.vertex2_y, item_i.vertex1_y);
    s1_d.cx     = sub(item_i.vertex3_x, item_i.vertex1_x);
    s1_d.cy     = sub(item_i.vertex3_y, item_i.vertex1_y);
    s1_d.adx    = sub(item_i.vertex1_x, item_i.query_x);
    s1_d.ady    = sub(item_i.vertex1_y, item_i.query_y);
    s1_d.bdx    = sub(item_i.vertex2_x, item_i.query_x);
    s1_d.bdy    = sub(item_i.vertex2_y, item_i.query_y);
    s1_d.cdx    = sub(item_i.vertex3_x, item_i.query_x);
    s1_d.cdy    = sub(item_i.vertex3_y, item_i.query_y);
    s1_d.e2x    = sub(item_i.vertex3_x, item_i.vertex2_x);
    s1_d.e2y    = sub(item_i.vertex3_y, item_i.vertex2_y);
    s1_d.e3x    = sub(item_i.vertex1_x, item_i.vertex3_x);
    s1_d.e3y    = sub(item_i.vertex1_y, item_i.vertex3_y);
    s1_d.base_x = item_i.vertex1_x;
    s1_d.base_y = item_i.vertex1_y;
  end

  // stage 2: small products
  always_comb begin
    s2_d.area2  = xprod(s1_q.bx, s1_q.cy, s1_q.by, s1_q.cx);
    s2_d.c1     = xprod(s1_q.by, s1_q.adx, s1_q.bx, s1_q.ady);
    s2_d.c2     = xprod(s1_q.e2y, s1_q.bdx, s1_q.e2x, s1_q.bdy);
    s2_d.c3     = xprod(s1_q.e3y, s1_q.cdx, s1_q.e3x, s1_q.cdy);
    s2_d.a2     = sqsum(s1_q.adx, s1_q.ady);
    s2_d.b2     = sqsum(s1_q.bdx, s1_q.bdy);
    s2_d.cc2    = sqsum(s1_q.cdx, s1_q.cdy);
    s2_d.lb     = sqsum(s1_q.bx, s1_q.by);
    s2_d.lc     = sqsum(s1_q.cx, s1_q.cy);
    s2_d.ma     = xprod(s1_q.bdx, s1_q.cdy, s1_q.bdy, s1_q.cdx);
    s2_d.mb     = xprod(s1_q.cdx, s1_q.ady, s1_q.cdy, s1_q.adx);
    s2_d.mc     = xprod(s1_q.adx, s1_q.bdy, s1_q.ady, s1_q.bdx);
    s2_d.bx     = s1_q.bx;
    s2_d.by     = s1_q.by;
    s2_d.cx     = s1_q.cx;
    s2_d.cy     = s1_q.cy;
    s2_d.base_x = s1_q.base_x;
    s2_d.base_y = s1_q.base_y;
  end

  // stage 3: wide partial products, orientation and edge tests
  always_comb begin
    abs_area    = s2_q.area2[CRW-1] ? CRW'(-s2_q.area2) : CRW'(s2_q.area2);
    s3_d.pal    = $signed({1'b0, s2_q.a2[LO-1:0]}) * s2_q.ma;
    s3_d.pbl    = $signed({1'b0, s2_q.b2[LO-1:0]}) * s2_q.mb;
    s3_d.pcl    = $signed({1'b0, s2_q.cc2[LO-1:0]}) * s2_q.mc;
    s3_d.pah    = $signed({1'b0, s2_q.a2[SQW-1:LO]}) * s2_q.ma;
    s3_d.pbh    = $signed({1'b0, s2_q.b2[SQW-1:LO]}) * s2_q.mb;
    s3_d.pch    = $signed({1'b0, s2_q.cc2[SQW-1:LO]}) * s2_q.mc;
    s3_d.lb_cy  = $signed({1'b0, s2_q.lb}) * s2_q.cy;
    s3_d.lc_by  = $signed({1'b0, s2_q.lc}) * s2_q.by;
    s3_d.lc_bx  = $signed({1'b0, s2_q.lc}) * s2_q.bx;
    s3_d.lb_cx  = $signed({1'b0, s2_q.lb}) * s2_q.cx;
    s3_d.cw     = s2_q.area2[CRW-1];
    s3_d.deg    = (s2_q.area2 == '0);
    s3_d.intri  = s2_q.area2[CRW-1] ?
                  (le_zero(s2_q.c1) & le_zero(s2_q.c2) & le_zero(s2_q.c3)) :
                  (~s2_q.c1[CRW-1] & ~s2_q.c2[CRW-1] & ~s2_q.c3[CRW-1]);
    s3_d.den    = {abs_area, 2'b00};
    s3_d.base_x = s2_q.base_x;
    s3_d.base_y = s2_q.base_y;
  end

  // stage 4: determinant and numerator sums
  always_comb begin
    ta          = (TW'(s3_q.pah) <<< LO) + TW'(s3_q.pal);
    tb          = (TW'(s3_q.pbh) <<< LO) + TW'(s3_q.pbl);
    tc          = (TW'(s3_q.pch) <<< LO) + TW'(s3_q.pcl);
    s4_d.det    = DTW'(ta) + DTW'(tb) + DTW'(tc);
    s4_d.nx     = NW'(s3_q.lb_cy) - NW'(s3_q.lc_by);
    s4_d.ny     = NW'(s3_q.lc_bx) - NW'(s3_q.lb_cx);
    s4_d.cw     = s3_q.cw;
    s4_d.deg    = s3_q.deg;
    s4_d.intri  = s3_q.intri;
    s4_d.den    = s3_q.den;
    s4_d.base_x = s3_q.base_x;
    s4_d.base_y = s3_q.base_y;
  end

  // stage 5: incircle decision, rounded dividends
  always_comb begin
    det_neg  = s4_q.det[DTW-1];
    det_zero = (s4_q.det == '0);
    abs_nx   = s4_q.nx[NW-1] ? NW'(-s4_q.nx) : NW'(s4_q.nx);
    abs_ny   = s4_q.ny[NW-1] ? NW'(-s4_q.ny) : NW'(s4_q.ny);
    half_den = MW'(s4_q.den >> 1);
    s5_d.flags.is_clockwise    = s4_q.cw;
    s5_d.flags.is_degenerate   = s4_q.deg;
    s5_d.flags.in_triangle     = s4_q.intri;
    s5_d.flags.in_circumcircle = ~s4_q.deg & (s4_q.cw ? (det_neg | det_zero) : ~det_neg);
    s5_d.neg_x  = s4_q.nx[NW-1] ^ s4_q.cw;
    s5_d.neg_y  = s4_q.ny[NW-1] ^ s4_q.cw;
    s5_d.mag_x  = (MW'(abs_nx) << (FB + 1)) + half_den;
    s5_d.mag_y  = (MW'(abs_ny) << (FB + 1)) + half_den;
    s5_d.base_x = s4_q.base_x;
    s5_d.base_y = s4_q.base_y;
    s5_d.den    = s4_q.den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    s4_q <= s4_d;
    s5_q <= s5_d;
  end

  assign valid_o = v5_q;
  assign data_o  = s5_q;

endmodule

// File: rtl/tpgt_div.sv
// pipelined restoring divider, one quotient bit per stage, two lanes
module tpgt_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tpgt_pkg::div_in_t    data_i,
  output logic                 valid_o,
  output tpgt_pkg::div_stage_t data_o
);

  localparam int QW  = tpgt_pkg::Q_W;
  localparam int MW  = tpgt_pkg::MAG_W;
  localparam int HW  = tpgt_pkg::HI_W;
  localparam int CPW = tpgt_pkg::CMP_W;
  localparam int RW  = tpgt_pkg::REM_W;
  localparam int DNW = tpgt_pkg::DEN_W;
  localparam int CB  = tpgt_pkg::COORD_BITS;
  localparam int TW  = RW + 1;

  function automatic tpgt_pkg::lane_t lane_init(input logic [MW-1:0] mag,
                                                input logic neg,
                                                input logic signed [CB-1:0] base,
                                                input logic [DNW-1:0] den);
    tpgt_pkg::lane_t l;
    logic [HW-1:0]   hi;
    logic [CPW-1:0]  hi_ext;
    hi       = mag[MW-1:QW];
    hi_ext   = CPW'(hi);
    l.neg    = neg;
    l.base   = base;
    // quotient would need more bits than kept: saturates anyway
    l.ovf    = (hi_ext >= CPW'(den));
    l.rem    = l.ovf ? '0 : RW'(hi_ext);
    l.acc    = mag[QW-1:0];
    return l;
  endfunction

  function automatic tpgt_pkg::lane_t lane_step(input tpgt_pkg::lane_t l,
                                                input logic [DNW-1:0] den);
    tpgt_pkg::lane_t r;
    logic [TW-1:0]   t;
    logic            take;
    t      = {l.rem, l.acc[QW-1]};
    take   = (t >= TW'(den));
    r      = l;
    r.rem  = take ? RW'(t - TW'(den)) : RW'(t);
    r.acc  = {l.acc[QW-2:0], take};
    return r;
  endfunction

  tpgt_pkg::div_stage_t st_q [QW+1];
  tpgt_pkg::div_stage_t st0_d;
  logic [QW:0]          vld_q;

  always_comb begin
    st0_d.flags  = data_i.flags;
    st0_d.den    = data_i.den;
    st0_d.lane_x = lane_init(data_i.mag_x, data_i.neg_x, data_i.base_x, data_i.den);
    st0_d.lane_y = lane_init(data_i.mag_y, data_i.neg_y, data_i.base_y, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st0_d;
    for (int k = 1; k <= QW; k++) begin
      st_q[k].flags  <= st_q[k-1].flags;
      st_q[k].den    <= st_q[k-1].den;
      st_q[k].lane_x <= lane_step(st_q[k-1].lane_x, st_q[k-1].den);
      st_q[k].lane_y <= lane_step(st_q[k-1].lane_y, st_q[k-1].den);
    end
  end

  assign valid_o = vld_q[QW];
  assign data_o  = st_q[QW];

endmodule

// File: rtl/tpgt_finish.sv
// sign, offset by the first vertex, saturation and the result register
module tpgt_finish (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tpgt_pkg::div_stage_t data_i,
  output logic                 done_o,
  output tpgt_pkg::out_item_t  result_o
);

  localparam int SW = tpgt_pkg::SUM_W;
  localparam int OB = tpgt_pkg::OUT_BITS;
  localparam int FB = tpgt_pkg::CENTER_FRAC_BITS;
  localparam logic [OB-1:0] MAX_CODE = {1'b0, {(OB-1){1'b1}}};
  localparam logic [OB-1:0] MIN_CODE = {1'b1, {(OB-1){1'b0}}};

  function automatic logic [OB-1:0] center(input tpgt_pkg::lane_t l, input logic deg);
    logic signed [SW-1:0] q;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] v;
    logic [SW-OB:0]       hi;
    logic [OB-1:0]        code;
    q  = $signed(SW'(l.acc));
    b  = SW'(l.base);
    b  = b <<< FB;
    v  = (l.neg ? -q : q) + b;
    hi = v[SW-1:OB-1];
    priority if (deg) begin
      code = '0;
    end else if (l.ovf) begin
      code = l.neg ? MIN_CODE : MAX_CODE;
    end else if (!((&hi) | ~(|hi))) begin
      code = v[SW-1] ? MIN_CODE : MAX_CODE;
    end else begin
      code = v[OB-1:0];
    end
    return code;
  endfunction

  tpgt_pkg::out_item_t res_d, res_q;
  logic                done_q;

  always_comb begin
    res_d.is_clockwise    = data_i.flags.is_clockwise;
    res_d.in_circumcircle = data_i.flags.in_circumcircle;
    res_d.in_triangle     = data_i.flags.in_triangle;
    res_d.is_degenerate   = data_i.flags.is_degenerate;
    res_d.center_x        = center(data_i.lane_x, data_i.flags.is_degenerate);
    res_d.center_y        = center(data_i.lane_y, data_i.flags.is_degenerate);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
